FILE: sv/ptbf_pkg.sv
// ----------------------------------------------------------------------------
// ptbf_pkg
// Types and constants shared by the point transform and box filter.
// ----------------------------------------------------------------------------
package ptbf_pkg;

	// Coordinate width; fixed here because it sets the payload struct widths.
	localparam int COORD_BITS = 20;

	localparam int THR_BITS   = 20;
	localparam int COEF_BITS  = 16;
	localparam int ROW_BITS   = 3 * COEF_BITS;
	localparam int VEC_BITS   = 60;
	localparam int INTEN_BITS = 8;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	// Register indices
	localparam logic [CFG_IDX_BITS-1:0] REG_X_THRESHOLD   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROT_ROW0      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROT_ROW1      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROT_ROW2      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_XYZ     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_CENTER    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HALF_SIZE = 3'd6;

	// Reset values: identity matrix, no shift, box centre (0, 500, -1000),
	// half extents (5000, 2000, 2000).
	localparam logic [ROW_BITS-1:0] RST_ROT_ROW0      = 48'h0000_0000_4000;
	localparam logic [ROW_BITS-1:0] RST_ROT_ROW1      = 48'h0000_4000_0000;
	localparam logic [ROW_BITS-1:0] RST_ROT_ROW2      = 48'h4000_0000_0000;
	localparam logic [VEC_BITS-1:0] RST_BOX_CENTER    = 60'hFFC18_001F4_00000;
	localparam logic [VEC_BITS-1:0] RST_BOX_HALF_SIZE = 60'h007D0_007D0_01388;

	// Source codes
	localparam logic SRC_PRIMARY   = 1'b0;
	localparam logic SRC_SECONDARY = 1'b1;

	typedef struct packed {
		logic                         cmd;
		logic                         point_valid;
		logic signed [COORD_BITS-1:0] in_x;
		logic signed [COORD_BITS-1:0] in_y;
		logic signed [COORD_BITS-1:0] in_z;
		logic        [INTEN_BITS-1:0] in_intensity;
	} point_in_t;

	typedef struct packed {
		logic                         out_source;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic        [INTEN_BITS-1:0] out_intensity;
	} point_out_t;

endpackage

FILE: sv/point_transform_box_filter.sv
// ----------------------------------------------------------------------------
// point_transform_box_filter
// Drops invalid points, gates primary points on x, rotates and translates
// secondary points, then drops anything inside the vehicle box.
// ----------------------------------------------------------------------------
// Path: a kept point is registered in the input, product, transform and result registers in turn.
// Throughput: one point per clock; the four-stage pipeline (input register,
//   product register, transform register, result register) moves as a whole
//   and holds only while a result waits under out_stall.
// Reset: arst_n clears all stage valids and loads the register defaults
//   (identity rotation, zero shift, default vehicle box).
module point_transform_box_filter #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// point input
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  ptbf_pkg::point_in_t                       in_data,
	// point output
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output ptbf_pkg::point_out_t                      out_data,
	// register writes
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [ptbf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [ptbf_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

	localparam int CB    = ptbf_pkg::COORD_BITS;
	localparam int CW    = ptbf_pkg::COEF_BITS;
	localparam int PRODW = CB + CW;        // one coefficient times one coordinate
	localparam int SUMW  = CB + CW + 3;    // sum of three, rounding, translation
	localparam int CMPW  = (CB > ptbf_pkg::THR_BITS ? CB : ptbf_pkg::THR_BITS) + 1;
	localparam int BOXW  = CB + 2;         // p - centre and +/- half extent
	localparam int EXTW  = 2 * ptbf_pkg::VEC_BITS + 8;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; an unused index
	// is ignored.
	// ------------------------------------------------------------------
	logic        [ptbf_pkg::THR_BITS-1:0] x_threshold_q;
	logic        [ptbf_pkg::ROW_BITS-1:0] rot_row_q [3];
	logic        [ptbf_pkg::VEC_BITS-1:0] shift_xyz_q;
	logic        [ptbf_pkg::VEC_BITS-1:0] box_center_q;
	logic        [ptbf_pkg::VEC_BITS-1:0] box_half_size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_threshold_q   <= '0;
			rot_row_q[0]    <= ptbf_pkg::RST_ROT_ROW0;
			rot_row_q[1]    <= ptbf_pkg::RST_ROT_ROW1;
			rot_row_q[2]    <= ptbf_pkg::RST_ROT_ROW2;
			shift_xyz_q     <= '0;
			box_center_q    <= ptbf_pkg::RST_BOX_CENTER;
			box_half_size_q <= ptbf_pkg::RST_BOX_HALF_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ptbf_pkg::REG_X_THRESHOLD:
					x_threshold_q <= cfg_data[ptbf_pkg::THR_BITS-1:0];
				ptbf_pkg::REG_ROT_ROW0:
					rot_row_q[0] <= cfg_data[ptbf_pkg::ROW_BITS-1:0];
				ptbf_pkg::REG_ROT_ROW1:
					rot_row_q[1] <= cfg_data[ptbf_pkg::ROW_BITS-1:0];
				ptbf_pkg::REG_ROT_ROW2:
					rot_row_q[2] <= cfg_data[ptbf_pkg::ROW_BITS-1:0];
				ptbf_pkg::REG_SHIFT_XYZ:
					shift_xyz_q <= cfg_data[ptbf_pkg::VEC_BITS-1:0];
				ptbf_pkg::REG_BOX_CENTER:
					box_center_q <= cfg_data[ptbf_pkg::VEC_BITS-1:0];
				ptbf_pkg::REG_BOX_HALF_SIZE:
					box_half_size_q <= cfg_data[ptbf_pkg::VEC_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Per-axis slots of the packed vectors. A slot reaching past bit 63
	// reads the zero padding, as does anything above the 60 stored bits.
	logic [EXTW-1:0]              shift_ext, center_ext, half_ext;
	logic signed [CB-1:0]         shift_a  [3];
	logic signed [CB-1:0]         center_a [3];
	logic        [CB-1:0]         half_a   [3];

	always_comb begin
		shift_ext  = EXTW'(shift_xyz_q);
		center_ext = EXTW'(box_center_q);
		half_ext   = EXTW'(box_half_size_q);
		for (int a = 0; a < 3; a++) begin
			shift_a[a]  = (a * CB >= 64) ? '0 : shift_ext[a*CB +: CB];
			center_a[a] = (a * CB >= 64) ? '0 : center_ext[a*CB +: CB];
			half_a[a]   = (a * CB >= 64) ? '0 : half_ext[a*CB +: CB];
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage moves unless the result register is
	// full and the consumer is stalling.
	// ------------------------------------------------------------------
	logic adv;
	logic out_vld_q;

	assign adv       = !(out_vld_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_vld_q;

	// Stage 1: input register. Invalid points never enter.
	logic                 vld_s1;
	ptbf_pkg::point_in_t  pnt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid && in_data.point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			pnt_s1 <= in_data;
		end
	end

	// Stage 2: nine coefficient products; x-threshold gate on primary points.
	logic signed [CB-1:0]   p_s1 [3];
	logic signed [CW-1:0]   coef [3][3];
	logic signed [CMPW-1:0] x_cmp, thr_cmp;
	logic                   keep_s1;

	always_comb begin
		p_s1[0] = pnt_s1.in_x;
		p_s1[1] = pnt_s1.in_y;
		p_s1[2] = pnt_s1.in_z;
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				coef[r][j] = rot_row_q[r][j*CW +: CW];
			end
		end
		x_cmp   = CMPW'(pnt_s1.in_x);
		thr_cmp = CMPW'($signed(x_threshold_q));
		keep_s1 = (pnt_s1.cmd == ptbf_pkg::SRC_SECONDARY) || (x_cmp >= thr_cmp);
	end

	logic                       vld_s2;
	logic                       src_s2;
	logic signed [CB-1:0]       p_s2 [3];
	logic [ptbf_pkg::INTEN_BITS-1:0] inten_s2;
	logic signed [PRODW-1:0]    prod_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 && keep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s2   <= pnt_s1.cmd;
			inten_s2 <= pnt_s1.in_intensity;
			for (int r = 0; r < 3; r++) begin
				p_s2[r] <= p_s1[r];
				for (int j = 0; j < 3; j++) begin
					prod_s2[r][j] <= PRODW'(coef[r][j]) * PRODW'(p_s1[j]);
				end
			end
		end
	end

	// Stage 3: sum, round half up, floor shift, translate, saturate; primary points pass unchanged.
	localparam logic signed [SUMW-1:0] RND = SUMW'(1) <<< (COEF_FRAC_BITS - 1);

	logic signed [SUMW-1:0] acc   [3];
	logic signed [SUMW-1:0] moved [3];
	logic signed [CB-1:0]   rot_q [3];
	logic signed [CB-1:0]   q_nxt [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = SUMW'(prod_s2[r][0]) + SUMW'(prod_s2[r][1])
			       + SUMW'(prod_s2[r][2]) + RND;
			moved[r] = (acc[r] >>> COEF_FRAC_BITS) + SUMW'(shift_a[r]);
			// out of range when the bits above the sign do not all match it
			if (moved[r][SUMW-1:CB-1] == '0 || moved[r][SUMW-1:CB-1] == '1) begin
				rot_q[r] = moved[r][CB-1:0];
			end else if (moved[r][SUMW-1]) begin
				rot_q[r] = {1'b1, {(CB-1){1'b0}}};
			end else begin
				rot_q[r] = {1'b0, {(CB-1){1'b1}}};
			end
			q_nxt[r] = (src_s2 == ptbf_pkg::SRC_SECONDARY) ? rot_q[r] : p_s2[r];
		end
	end

	logic                            vld_s3;
	logic                            src_s3;
	logic signed [CB-1:0]            q_s3 [3];
	logic [ptbf_pkg::INTEN_BITS-1:0] inten_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s3   <= src_s2;
			inten_s3 <= inten_s2;
			for (int r = 0; r < 3; r++) begin
				q_s3[r] <= q_nxt[r];
			end
		end
	end

	// Stage 4: vehicle box test, bounds inclusive, into the result register.
	logic signed [BOXW-1:0] offs [3];
	logic signed [BOXW-1:0] lim  [3];
	logic                   in_box;

	always_comb begin
		in_box = 1'b1;
		for (int a = 0; a < 3; a++) begin
			offs[a] = BOXW'(q_s3[a]) - BOXW'(center_a[a]);
			lim[a]  = BOXW'(half_a[a]);
			if (offs[a] < -lim[a] || offs[a] > lim[a]) begin
				in_box = 1'b0;
			end
		end
	end

	ptbf_pkg::point_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s3 && !in_box;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_source    <= src_s3;
			out_q.out_x         <= q_s3[0];
			out_q.out_y         <= q_s3[1];
			out_q.out_z         <= q_s3[2];
			out_q.out_intensity <= inten_s3;
		end
	end

	assign out_data = out_q;

endmodule
